@@ sv/fl8_pkg.sv @@
// ----------------------------------------------------------------------------
// fl8_pkg: shared types and constants for the fletcher-8 packet framer
// Command kinds passed from the front end to the back end, the command
// transaction layout and the register map of the configuration port.
// ----------------------------------------------------------------------------
package fl8_pkg;

   // widths fixed by the field layout
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int STEP_W      = 3;

   // default depth of the command queue between front and back
   localparam int CMD_QUEUE_DEPTH = 4;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 2'd1;

   // back end step numbers
   localparam logic [STEP_W-1:0] STEP_SYNC_FIRST  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_SYNC_SECOND = 3'd1;
   localparam logic [STEP_W-1:0] STEP_TYPE        = 3'd2;
   localparam logic [STEP_W-1:0] STEP_LEN_LOW     = 3'd3;
   localparam logic [STEP_W-1:0] STEP_LEN_HIGH    = 3'd4;
   localparam logic [STEP_W-1:0] STEP_HDR_SUM_A   = 3'd5;
   localparam logic [STEP_W-1:0] STEP_HDR_SUM_B   = 3'd6;
   localparam logic [STEP_W-1:0] STEP_DATA        = 3'd0;
   localparam logic [STEP_W-1:0] STEP_DAT_SUM_A   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_DAT_SUM_B   = 3'd2;

   // classified command kinds
   typedef enum logic [1:0] {
      CMD_START,
      CMD_DATA,
      CMD_MISUSE
   } cmd_kind_type;

   // one command transaction through the queue
   typedef struct packed {
      cmd_kind_type          kind;
      logic [BYTE_W-1:0]     frame_type;
      logic [LEN_W-1:0]      payload_length;
      logic [BYTE_W-1:0]     data_byte;
      logic                  zero_len;    // start of an empty frame
      logic                  last_byte;   // data byte that closes the frame
   } cmd_type;

endpackage

@@ sv/fletcher8_packet_framer.sv @@
// ----------------------------------------------------------------------------
// fletcher8_packet_framer: framed byte packets with fletcher-8 checksum
//
//   channel   direction  handshake              payload
//   req       in         req_push / req_full    req_type, frame_type,
//                                               payload_length, data_byte
//   rsp       out        rsp_empty / rsp_pop    out_byte, run_last,
//                                               frame_end, misuse
//   csr       in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One response byte per cycle leaves the sequencer while the receiver pops and
// commands are queued; a data request gives one byte, a start request five,
// and a frame close adds two checksum bytes. Requests are taken every cycle
// until the command queue (QUEUE_DEPTH entries) fills. A request passes the
// command queue and the registered response stage before its first byte shows.
// Synchronous reset empties the queue and response stage and clears sums.
// csr writes are always taken.
// ----------------------------------------------------------------------------
module fletcher8_packet_framer #(
   parameter int QUEUE_DEPTH = fl8_pkg::CMD_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_type,
   input  logic [fl8_pkg::BYTE_W-1:0]        req_frame_type,
   input  logic [fl8_pkg::LEN_W-1:0]         req_payload_length,
   input  logic [fl8_pkg::BYTE_W-1:0]        req_data_byte,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [fl8_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_run_last,
   output logic                              rsp_frame_end,
   output logic                              rsp_misuse,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fl8_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fl8_pkg::BYTE_W-1:0]        csr_wdata
);
   import fl8_pkg::*;

   logic [BYTE_W-1:0]  sync_first_ff, sync_second_ff;
   cmd_type            front_cmd, head_cmd;
   logic               cmd_push, queue_full, queue_empty, queue_pop;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= '0;
         sync_second_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SYNC_FIRST) begin
            sync_first_ff <= csr_wdata;
         end else if (csr_index == CSR_SYNC_SECOND) begin
            sync_second_ff <= csr_wdata;
         end
      end
   end

   // front end classifier
   fl8_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_type           (req_type),
      .req_frame_type     (req_frame_type),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .queue_full         (queue_full),
      .cmd_push           (cmd_push),
      .cmd                (front_cmd)
   );

   assign req_full = queue_full;

   // command queue
   fl8_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty)
   );

   // back end sequencer
   fl8_back u_back (
      .clock         (clock),
      .reset         (reset),
      .sync_first    (sync_first_ff),
      .sync_second   (sync_second_ff),
      .head_cmd      (head_cmd),
      .queue_empty   (queue_empty),
      .queue_pop     (queue_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end),
      .rsp_misuse    (rsp_misuse)
   );

   // frame end is always the last byte of its transaction
   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |-> rsp_run_last)
      else $error("frame end without run last");

   // misuse responses are single bytes that never close a frame
   a_misuse_alone: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_misuse) |-> (rsp_run_last && !rsp_frame_end))
      else $error("misuse response malformed");

   // nothing is shown straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("block not empty after reset");

   // the queue never pops a command while empty
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      queue_empty |-> !queue_pop)
      else $error("command popped from empty queue");

endmodule

@@ sv/fl8_front.sv @@
// ----------------------------------------------------------------------------
// fl8_front: request classifier
// Accepts request transactions, tracks the open frame and the bytes still
// expected, and turns each request into one command for the back end.
// ----------------------------------------------------------------------------
module fl8_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic                         req_type,
   input  logic [fl8_pkg::BYTE_W-1:0]   req_frame_type,
   input  logic [fl8_pkg::LEN_W-1:0]    req_payload_length,
   input  logic [fl8_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                         queue_full,
   output logic                         cmd_push,
   output fl8_pkg::cmd_type             cmd
);
   import fl8_pkg::*;

   logic              frame_open_ff, frame_open_in;
   logic [LEN_W-1:0]  bytes_left_ff, bytes_left_in;
   logic              accept;
   logic              closing;

   assign accept   = req_push && !queue_full;
   assign cmd_push = accept;
   assign closing  = (bytes_left_ff == LEN_W'(1));

   // classify the request and work out the frame state after it
   always_comb begin
      frame_open_in       = frame_open_ff;
      bytes_left_in       = bytes_left_ff;
      cmd.frame_type      = req_frame_type;
      cmd.payload_length  = req_payload_length;
      cmd.data_byte       = req_data_byte;
      cmd.zero_len        = (req_payload_length == '0);
      cmd.last_byte       = closing;
      if (req_type == 1'b0) begin
         cmd.kind      = CMD_START;
         bytes_left_in = req_payload_length;
         frame_open_in = (req_payload_length != '0);
      end else if (!frame_open_ff) begin
         cmd.kind = CMD_MISUSE;
      end else begin
         cmd.kind      = CMD_DATA;
         bytes_left_in = bytes_left_ff - LEN_W'(1);
         frame_open_in = !closing;
      end
   end

   // frame tracking registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= '0;
      end else if (accept) begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

@@ sv/fl8_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// fl8_cmd_fifo: command queue
// Short first-in first-out queue of command transactions that decouples the
// classifier from the byte sequencer.
// ----------------------------------------------------------------------------
module fl8_cmd_fifo #(
   parameter int DEPTH = fl8_pkg::CMD_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fl8_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output fl8_pkg::cmd_type  head_cmd,
   output logic              empty
);
   import fl8_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ sv/fl8_back.sv @@
// ----------------------------------------------------------------------------
// fl8_back: byte sequencer
// Walks each queued command through its output bytes, keeps the running
// Fletcher sums and drives the registered response stage.
// ----------------------------------------------------------------------------
module fl8_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [fl8_pkg::BYTE_W-1:0]   sync_first,
   input  logic [fl8_pkg::BYTE_W-1:0]   sync_second,
   input  fl8_pkg::cmd_type             head_cmd,
   input  logic                         queue_empty,
   output logic                         queue_pop,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output logic [fl8_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                         rsp_run_last,
   output logic                         rsp_frame_end,
   output logic                         rsp_misuse
);
   import fl8_pkg::*;

   logic [STEP_W-1:0]  step_ff;
   logic [BYTE_W-1:0]  sum_low_ff, sum_high_ff;
   logic               out_valid_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               run_last_ff, frame_end_ff, misuse_ff;

   logic               load, fire;
   logic               final_step, accumulate, restart;
   logic [BYTE_W-1:0]  sel_byte;
   logic               sel_frame_end, sel_misuse;
   logic [BYTE_W-1:0]  base_low, base_high, new_low, new_high;

   assign load      = !out_valid_ff || rsp_pop;
   assign fire      = load && !queue_empty;
   assign queue_pop = fire && final_step;

   // decode the current command step
   always_comb begin
      sel_byte      = '0;
      sel_frame_end = 1'b0;
      sel_misuse    = 1'b0;
      final_step    = 1'b1;
      accumulate    = 1'b0;
      restart       = 1'b0;
      unique case (head_cmd.kind)
         CMD_START: begin
            accumulate = (step_ff <= STEP_LEN_HIGH);
            restart    = (step_ff == STEP_SYNC_FIRST);
            final_step = head_cmd.zero_len ? (step_ff == STEP_HDR_SUM_B)
                                           : (step_ff == STEP_LEN_HIGH);
            case (step_ff)
               STEP_SYNC_FIRST:  sel_byte = sync_first;
               STEP_SYNC_SECOND: sel_byte = sync_second;
               STEP_TYPE:        sel_byte = head_cmd.frame_type;
               STEP_LEN_LOW:     sel_byte = head_cmd.payload_length[BYTE_W-1:0];
               STEP_LEN_HIGH:    sel_byte = head_cmd.payload_length[LEN_W-1:BYTE_W];
               STEP_HDR_SUM_A:   sel_byte = sum_low_ff;
               default:          sel_byte = sum_high_ff;
            endcase
            sel_frame_end = (step_ff == STEP_HDR_SUM_B);
         end
         CMD_DATA: begin
            accumulate = (step_ff == STEP_DATA);
            final_step = head_cmd.last_byte ? (step_ff == STEP_DAT_SUM_B)
                                            : (step_ff == STEP_DATA);
            case (step_ff)
               STEP_DATA:      sel_byte = head_cmd.data_byte;
               STEP_DAT_SUM_A: sel_byte = sum_low_ff;
               default:        sel_byte = sum_high_ff;
            endcase
            sel_frame_end = (step_ff == STEP_DAT_SUM_B);
         end
         default: begin
            sel_misuse = 1'b1;
         end
      endcase
   end

   // fletcher update, fresh sums at the first sync byte
   assign base_low  = restart ? '0 : sum_low_ff;
   assign base_high = restart ? '0 : sum_high_ff;
   assign new_low   = base_low + sel_byte;
   assign new_high  = base_high + new_low;

   // step counter, sums and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         sum_low_ff   <= '0;
         sum_high_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            step_ff <= final_step ? '0 : step_ff + STEP_W'(1);
            if (accumulate) begin
               sum_low_ff  <= new_low;
               sum_high_ff <= new_high;
            end
         end
         if (load) begin
            out_valid_ff <= !queue_empty;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff  <= sel_byte;
         run_last_ff  <= final_step;
         frame_end_ff <= sel_frame_end;
         misuse_ff    <= sel_misuse;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_frame_end = frame_end_ff;
   assign rsp_misuse    = misuse_ff;

endmodule

@@ verif/tb_fletcher8_packet_framer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fletcher8_packet_framer: self-checking bench for the fletcher-8 framer
// Requests are fed from a pending queue by a clocked driver. Each accepted
// request is run through a local framer predictor, and the output bytes it
// gives are queued. A clocked monitor pops the responses and compares every
// field with the oldest queued byte. Sync bytes are rewritten between phases
// while the block is idle. A long receiver hold-off fills the block's queue.
// ----------------------------------------------------------------------------
module tb_fletcher8_packet_framer;
   import fl8_pkg::*;

   localparam int RUN_LIMIT     = 500000;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 200;
   localparam int PHASE_ITEMS   = 50;

   // register indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_DATA  = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type       kind;
      logic [BYTE_W-1:0]  frame_type;
      logic [LEN_W-1:0]   payload_length;
      logic [BYTE_W-1:0]  data_byte;
   } framer_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               run_last;
      logic               frame_end;
      logic               misuse;
   } framer_byte_type;

   // block ports
   logic                    clock              = 1'b0;
   logic                    reset              = 1'b1;
   logic                    req_push           = 1'b0;
   logic                    req_full;
   logic                    req_type           = 1'b0;
   logic [BYTE_W-1:0]       req_frame_type     = '0;
   logic [LEN_W-1:0]        req_payload_length = '0;
   logic [BYTE_W-1:0]       req_data_byte      = '0;
   logic                    rsp_empty;
   logic                    rsp_pop            = 1'b0;
   logic [BYTE_W-1:0]       rsp_out_byte;
   logic                    rsp_run_last;
   logic                    rsp_frame_end;
   logic                    rsp_misuse;
   logic                    csr_valid          = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index          = '0;
   logic [BYTE_W-1:0]       csr_wdata          = '0;

   // predictor state and configuration copy
   logic [BYTE_W-1:0]  sync_first_cfg  = '0;
   logic [BYTE_W-1:0]  sync_second_cfg = '0;
   logic [BYTE_W-1:0]  frame_sum_a     = '0;
   logic [BYTE_W-1:0]  frame_sum_b     = '0;
   logic [LEN_W-1:0]   payload_left    = '0;
   logic               frame_is_open   = 1'b0;

   framer_req_type   pending_reqs_q[$];
   framer_byte_type  expected_bytes_q[$];
   framer_req_type   held_req;

   // idling controls; the mode flags change at the falling edge only
   bit  send_no_gaps = 1'b0;
   bit  recv_no_gaps = 1'b0;
   bit  rsp_hold     = 1'b0;
   int  send_gap     = 0;
   int  recv_gap     = 0;

   int  error_count    = 0;
   int  reqs_accepted  = 0;
   int  bytes_checked  = 0;
   int  frames_closed  = 0;
   int  misuse_bytes   = 0;
   int  full_cycles    = 0;
   int  csr_writes     = 0;
   int  cycle_count    = 0;

   fletcher8_packet_framer DUT (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_type           (req_type),
      .req_frame_type     (req_frame_type),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_misuse         (rsp_misuse),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t ns mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic expect_byte(logic [BYTE_W-1:0] b, logic last, logic fend, logic mis);
      framer_byte_type e;
      e.out_byte  = b;
      e.run_last  = last;
      e.frame_end = fend;
      e.misuse    = mis;
      expected_bytes_q.insert(expected_bytes_q.size(), e);
   endtask

   task automatic close_frame();
      expect_byte(frame_sum_a, 1'b0, 1'b0, 1'b0);
      expect_byte(frame_sum_b, 1'b1, 1'b1, 1'b0);
      frame_is_open = 1'b0;
   endtask

   // output bytes produced by one request
   task automatic predict_framer(framer_req_type r);
      logic [BYTE_W-1:0] hdr [5];
      if (r.kind == REQ_START) begin
         hdr = '{sync_first_cfg, sync_second_cfg, r.frame_type,
                 r.payload_length[7:0], r.payload_length[15:8]};
         frame_sum_a = '0;
         frame_sum_b = '0;
         for (int k = 0; k < 5; k++) begin
            frame_sum_a += hdr[k];
            frame_sum_b += frame_sum_a;
            expect_byte(hdr[k], (k == 4) && (r.payload_length != 0), 1'b0, 1'b0);
         end
         payload_left  = r.payload_length;
         frame_is_open = 1'b1;
         if (r.payload_length == 0) close_frame();
      end else if (!frame_is_open) begin
         expect_byte('0, 1'b1, 1'b0, 1'b1);
      end else begin
         frame_sum_a += r.data_byte;
         frame_sum_b += frame_sum_a;
         payload_left--;
         if (payload_left == 0) begin
            expect_byte(r.data_byte, 1'b0, 1'b0, 1'b0);
            close_frame();
         end else begin
            expect_byte(r.data_byte, 1'b1, 1'b0, 1'b0);
         end
      end
   endtask

   // request builders, unused fields carry random values
   task automatic queue_start(logic [BYTE_W-1:0] ftype, logic [LEN_W-1:0] len);
      framer_req_type r;
      r.kind           = REQ_START;
      r.frame_type     = ftype;
      r.payload_length = len;
      r.data_byte      = BYTE_W'($urandom_range(0, 255));
      pending_reqs_q.insert(pending_reqs_q.size(), r);
   endtask

   task automatic queue_data(logic [BYTE_W-1:0] b);
      framer_req_type r;
      r.kind           = REQ_DATA;
      r.frame_type     = BYTE_W'($urandom_range(0, 255));
      r.payload_length = LEN_W'($urandom_range(0, 65535));
      r.data_byte      = b;
      pending_reqs_q.insert(pending_reqs_q.size(), r);
   endtask

   // mostly whole frames, some stray bytes and cut-short frames
   task automatic queue_random(int n);
      int count;
      int roll;
      int len;
      int sent;
      count = 0;
      while (count < n) begin
         roll = $urandom_range(0, 99);
         len  = $urandom_range(0, 99);
         if (len < 10) len = 0;
         else if (len < 80) len = $urandom_range(1, 8);
         else if (len < 95) len = $urandom_range(9, 30);
         else len = $urandom_range(250, 260);
         if (roll < 85) begin
            // keep the phase within its item budget
            if (count + 1 + len > n) len = n - count - 1;
            queue_start(BYTE_W'($urandom_range(0, 255)), LEN_W'(len));
            for (int k = 0; k < len; k++) queue_data(BYTE_W'($urandom_range(0, 255)));
            count += 1 + len;
         end else if (roll < 93) begin
            queue_data(BYTE_W'($urandom_range(0, 255)));
            count++;
         end else begin
            len  = $urandom_range(2, 10);
            sent = $urandom_range(0, len - 1);
            if (count + 1 + sent > n) sent = n - count - 1;
            queue_start(BYTE_W'($urandom_range(0, 255)), LEN_W'(len));
            for (int k = 0; k < sent; k++) queue_data(BYTE_W'($urandom_range(0, 255)));
            count += 1 + sent;
         end
      end
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [BYTE_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SYNC_FIRST:  sync_first_cfg = value;
         CSR_SYNC_SECOND: sync_second_cfg = value;
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   // sender stays quiet until every outstanding byte has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs_q.size() != 0 || req_push || expected_bytes_q.size() != 0);
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      logic next_push;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         next_push = req_push;
         if (req_push && !req_full) begin
            predict_framer(held_req);
            reqs_accepted++;
            next_push = 1'b0;
         end
         if (req_push && req_full) full_cycles++;
         if (!next_push) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_reqs_q.size() != 0) begin
               held_req           = pending_reqs_q.pop_front();
               req_type           <= held_req.kind;
               req_frame_type     <= held_req.frame_type;
               req_payload_length <= held_req.payload_length;
               req_data_byte      <= held_req.data_byte;
               next_push          = 1'b1;
               send_gap           = send_no_gaps ? 0 : idle_gap();
            end
         end
         req_push <= next_push;
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : watch_rsp
      framer_byte_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            bytes_checked++;
            if (expected_bytes_q.size() == 0) begin
               report_mismatch("transaction with none outstanding",
                               16'(rsp_out_byte), 16'h0000);
            end else begin
               want = expected_bytes_q.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch("out_byte", 16'(rsp_out_byte), 16'(want.out_byte));
               if (rsp_run_last !== want.run_last)
                  report_mismatch("run_last", 16'(rsp_run_last), 16'(want.run_last));
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch("frame_end", 16'(rsp_frame_end), 16'(want.frame_end));
               if (rsp_misuse !== want.misuse)
                  report_mismatch("misuse", 16'(rsp_misuse), 16'(want.misuse));
               if (want.frame_end) frames_closed++;
               if (want.misuse) misuse_bytes++;
            end
            recv_gap = recv_no_gaps ? 0 : idle_gap();
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !rsp_hold;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_fletcher8_packet_framer: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: sync bytes still at reset value
      queue_data(8'h00);             // byte with no frame open
      queue_data(8'hff);
      queue_start(8'h00, 16'h0000);  // empty frame closes at once
      queue_start(8'hff, 16'hffff);  // longest frame, dropped below
      queue_data(8'ha5);
      queue_start(8'h5a, 16'h0002);  // start drops the open frame
      queue_data(8'h00);
      queue_data(8'hff);
      queue_data(8'h3c);             // stray byte after close
      queue_start(8'h01, 16'h0001);
      queue_data(8'hff);
      queue_start(8'h80, 16'h0100);
      queue_data(8'h01);
      queue_start(8'h7f, 16'h0003);
      queue_data(8'hff);
      queue_data(8'hff);
      queue_data(8'hff);
      queue_start(8'hff, 16'h0000);
      queue_data(8'h00);
      wait_idle();

      // all-ones sync, no idling on either side
      write_csr(CSR_SYNC_FIRST, 8'hff);
      write_csr(CSR_SYNC_SECOND, 8'hff);
      @(negedge clock);
      send_no_gaps = 1'b1;
      recv_no_gaps = 1'b1;
      queue_random(PHASE_ITEMS);
      wait_idle();

      // zero sync, spare index ignored; receiver holds off to fill the block
      recv_no_gaps = 1'b0;
      write_csr(CSR_SYNC_FIRST, 8'h00);
      write_csr(CSR_SYNC_SECOND, 8'h00);
      write_csr(CSR_SPARE_A, 8'hff);
      @(negedge clock);
      fork
         begin
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      queue_random(PHASE_ITEMS);
      wait_idle();

      // random sync values with random idling
      send_no_gaps = 1'b0;
      for (int p = 0; p < 3; p++) begin
         write_csr(CSR_SYNC_FIRST, BYTE_W'($urandom_range(0, 255)));
         write_csr(CSR_SYNC_SECOND, BYTE_W'($urandom_range(0, 255)));
         if (p == 1) write_csr(CSR_SPARE_B, BYTE_W'($urandom_range(0, 255)));
         @(negedge clock);
         queue_random(PHASE_ITEMS);
         wait_idle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_bytes_q.size() != 0)
         report_mismatch("bytes never produced", 16'h0000, 16'(expected_bytes_q.size()));
      $display("covered %0d requests, %0d output bytes, %0d closed frames, %0d misuse bytes",
               reqs_accepted, bytes_checked, frames_closed, misuse_bytes);
      $display("%0d csr writes, %0d cycles with requests held off by a full queue",
               csr_writes, full_cycles);
      if (error_count == 0) begin
         $display("tb_fletcher8_packet_framer: PASS");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb_fletcher8_packet_framer: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/fl8_pkg.sv
sv/fl8_front.sv
sv/fl8_cmd_fifo.sv
sv/fl8_back.sv
sv/fletcher8_packet_framer.sv
verif/tb_fletcher8_packet_framer.sv
